// ===== rtl/eafc_pkg.sv =====
// Package for the encoder angle frame checker: frame layout constants,
// stream widths and the byte-wise CRC-8 function. No dependencies.
package eafc_pkg;

   // Stream widths; the data widths are padded to whole bytes.
   localparam int REQ_DATA_WIDTH = 8;
   localparam int REQ_USER_WIDTH = 1;
   localparam int RSP_DATA_WIDTH = 112;
   localparam int RSP_USER_WIDTH = 1;

   // Reading layout.
   localparam int ANGLE_BITS   = 21;
   localparam int STATUS_WIDTH = 3;
   localparam int PAYLOAD_BITS = 24;
   localparam int OUT_COUNT_BITS = 32;

   // Degree scaling: a full turn of 360 degrees fits in 9 bits.
   localparam int DEG_SCALE_BITS = 9;
   localparam logic [DEG_SCALE_BITS-1:0] FULL_TURN_DEG = 9'd360;
   localparam int MULT_WIDTH = ANGLE_BITS + DEG_SCALE_BITS;

   // CRC-8, polynomial 0x1D, MSB first.
   localparam logic [7:0] CRC_POLY = 8'h1D;
   localparam logic [7:0] CRC_INIT = 8'h00;
   localparam logic [7:0] CRC_MSB  = 8'h80;

   // Byte positions within a six-byte frame.
   typedef enum logic [2:0] {
      POS_ECHO_0  = 3'd0,
      POS_ECHO_1  = 3'd1,
      POS_DATA_0  = 3'd2,
      POS_DATA_1  = 3'd3,
      POS_DATA_2  = 3'd4,
      POS_CHECK   = 3'd5
   } pos_type;

   localparam int COUNTER_WIDTH_DEF        = 32;
   localparam int DEGREE_FRACTION_BITS_DEF = 12;

   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      acc = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((acc & CRC_MSB) != 8'h00) begin
            acc = {acc[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[6:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

// ===== rtl/encoder_angle_frame_checker.sv =====
// Encoder angle frame checker: one input byte register, the frame tracker,
// CRC check and degree scaling, and one result register. Uses eafc_pkg.
//
// A check byte waits in the input register until it can load the result register.
// Throughput: one byte per cycle; the input register drains while a result
// waits; it stalls only on a check byte while a full result register is not read.
// Reset: synchronous, active high; clears position, CRC, reading and counters.
module encoder_angle_frame_checker #(
   parameter int COUNTER_WIDTH        = eafc_pkg::COUNTER_WIDTH_DEF,
   parameter int DEGREE_FRACTION_BITS = eafc_pkg::DEGREE_FRACTION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] rx_byte
   input  logic [eafc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // [0] frame_start
   input  logic [eafc_pkg::REQ_USER_WIDTH-1:0]  req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [20:0] angle_count, [41:21] angle_degrees, [44:42] sensor_status,
   // [76:45] frames_seen, [108:77] crc_failures, [111:109] zero
   output logic [eafc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // [0] crc_ok
   output logic [eafc_pkg::RSP_USER_WIDTH-1:0]  rsp_tuser
);
   import eafc_pkg::*;

   localparam int DEG_SHIFT = ANGLE_BITS - DEGREE_FRACTION_BITS;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   // Frame state.
   pos_type                     pos_ff, pos_in;
   logic [7:0]                  crc_ff, crc_in;
   logic [PAYLOAD_BITS-1:0]     payload_ff, payload_in;
   logic [ANGLE_BITS-1:0]       angle_ff, angle_in;
   logic [STATUS_WIDTH-1:0]     status_ff, status_in;
   logic [COUNTER_WIDTH-1:0]    frames_ff, frames_in;
   logic [COUNTER_WIDTH-1:0]    errors_ff, errors_in;

   // Result register.
   logic                        rsp_valid_ff;
   logic                        rsp_ok_ff;
   logic [ANGLE_BITS-1:0]       rsp_angle_ff;
   logic [ANGLE_BITS-1:0]       rsp_deg_ff;
   logic [STATUS_WIDTH-1:0]     rsp_status_ff;
   logic [OUT_COUNT_BITS-1:0]   rsp_frames_ff;
   logic [OUT_COUNT_BITS-1:0]   rsp_errors_ff;

   pos_type                     pos_eff;
   logic                        emits;
   logic                        out_free;
   logic                        step;
   logic                        out_load;
   logic                        crc_match;
   logic [MULT_WIDTH-1:0]       deg_product;
   logic [MULT_WIDTH-1:0]       deg_shifted;
   logic [OUT_COUNT_BITS-1:0]   frames_out;
   logic [OUT_COUNT_BITS-1:0]   errors_out;

   assign pos_eff   = in_start_ff ? POS_ECHO_0 : pos_ff;
   assign emits     = (pos_eff == POS_CHECK);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign step      = in_valid_ff && (!emits || out_free);
   assign out_load  = step && emits;
   assign req_tready = !in_valid_ff || step;
   assign crc_match = (crc_ff == in_byte_ff);

   always_comb begin
      pos_in     = pos_eff;
      crc_in     = crc_ff;
      payload_in = payload_ff;
      angle_in   = angle_ff;
      status_in  = status_ff;
      frames_in  = frames_ff;
      errors_in  = errors_ff;
      unique case (pos_eff)
         POS_ECHO_0: begin
            crc_in     = CRC_INIT;
            payload_in = '0;
            pos_in     = POS_ECHO_1;
         end
         POS_ECHO_1: pos_in = POS_DATA_0;
         POS_DATA_0, POS_DATA_1, POS_DATA_2: begin
            crc_in     = crc_byte(crc_ff, in_byte_ff);
            payload_in = {payload_ff[PAYLOAD_BITS-9:0], in_byte_ff};
            pos_in     = (pos_eff == POS_DATA_2) ? POS_CHECK
                         : ((pos_eff == POS_DATA_0) ? POS_DATA_1 : POS_DATA_2);
         end
         POS_CHECK: begin
            pos_in    = POS_ECHO_0;
            frames_in = frames_ff + COUNTER_WIDTH'(1);
            if (crc_match) begin
               angle_in  = payload_ff[PAYLOAD_BITS-1:STATUS_WIDTH];
               status_in = payload_ff[STATUS_WIDTH-1:0];
            end else begin
               errors_in = errors_ff + COUNTER_WIDTH'(1);
            end
         end
         default: pos_in = POS_ECHO_0;
      endcase
   end

   // Degrees = angle * 360 * 2^F / 2^21, truncated.
   assign deg_product = MULT_WIDTH'(angle_in) * MULT_WIDTH'(FULL_TURN_DEG);
   assign deg_shifted = deg_product >> DEG_SHIFT;

   generate
      if (COUNTER_WIDTH >= OUT_COUNT_BITS) begin : g_cnt_wide
         assign frames_out = frames_in[OUT_COUNT_BITS-1:0];
         assign errors_out = errors_in[OUT_COUNT_BITS-1:0];
      end else begin : g_cnt_narrow
         assign frames_out = {{(OUT_COUNT_BITS-COUNTER_WIDTH){1'b0}}, frames_in};
         assign errors_out = {{(OUT_COUNT_BITS-COUNTER_WIDTH){1'b0}}, errors_in};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pos_ff       <= POS_ECHO_0;
         crc_ff       <= CRC_INIT;
         payload_ff   <= '0;
         angle_ff     <= '0;
         status_ff    <= '0;
         frames_ff    <= '0;
         errors_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (step) begin
            pos_ff     <= pos_in;
            crc_ff     <= crc_in;
            payload_ff <= payload_in;
            angle_ff   <= angle_in;
            status_ff  <= status_in;
            frames_ff  <= frames_in;
            errors_ff  <= errors_in;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata[7:0];
         in_start_ff <= req_tuser[0];
      end
      if (out_load) begin
         rsp_ok_ff     <= crc_match;
         rsp_angle_ff  <= angle_in;
         rsp_deg_ff    <= deg_shifted[ANGLE_BITS-1:0];
         rsp_status_ff <= status_in;
         rsp_frames_ff <= frames_out;
         rsp_errors_ff <= errors_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {3'b000, rsp_errors_ff, rsp_frames_ff, rsp_status_ff,
                        rsp_deg_ff, rsp_angle_ff};

`ifndef SYNTH
   // The frame position never leaves the six-byte range.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == POS_ECHO_0) || (pos_ff == POS_ECHO_1) || (pos_ff == POS_DATA_0) ||
      (pos_ff == POS_DATA_1) || (pos_ff == POS_DATA_2) || (pos_ff == POS_CHECK))
      else $error("frame position out of range");

   // Taking a check byte always presents a result in the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid)
      else $error("check byte taken without a result");

   // A matching CRC leaves the failure count alone; a mismatch keeps the reading.
   a_ok_no_error: assert property (@(posedge clock) disable iff (reset)
      (out_load && crc_match) |=> $stable(errors_ff))
      else $error("failure counted on a good frame");

   a_bad_keeps: assert property (@(posedge clock) disable iff (reset)
      (out_load && !crc_match) |=> ($stable(angle_ff) && $stable(status_ff)))
      else $error("reading changed on a bad frame");

   // The frame counter moves only when a result is loaded.
   a_frames_step: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable(frames_ff))
      else $error("frame counter moved without a result");
`endif

endmodule

// ===== sim/encoder_angle_frame_checker_check.sv =====
// Scoreboard for the encoder angle frame checker: watches both stream channels,
// predicts each result from the accepted bytes and compares it. Uses eafc_pkg.
`timescale 1ns / 100ps

module encoder_angle_frame_checker_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   // [7:0] rx_byte
   input  logic [eafc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // [0] frame_start
   input  logic [eafc_pkg::REQ_USER_WIDTH-1:0]  req_tuser,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [20:0] angle_count, [41:21] angle_degrees, [44:42] sensor_status,
   // [76:45] frames_seen, [108:77] crc_failures, [111:109] zero
   input  logic [eafc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // [0] crc_ok
   input  logic [eafc_pkg::RSP_USER_WIDTH-1:0]  rsp_tuser,
   output int                                   mismatch_count,
   output int                                   readings_pending
);
   import eafc_pkg::*;

   localparam int FRACTION_BITS = DEGREE_FRACTION_BITS_DEF;

   typedef struct {
      logic                      crc_ok;
      logic [ANGLE_BITS-1:0]     angle;
      logic [ANGLE_BITS-1:0]     degrees;
      logic [STATUS_WIDTH-1:0]   status;
      logic [OUT_COUNT_BITS-1:0] frames;
      logic [OUT_COUNT_BITS-1:0] errors;
   } angle_reading_type;

   angle_reading_type expected_readings[$];

   // Predicted frame tracker state.
   pos_type                   frame_pos;
   logic [7:0]                frame_crc;
   logic [PAYLOAD_BITS-1:0]   payload;
   logic [ANGLE_BITS-1:0]     good_angle;
   logic [STATUS_WIDTH-1:0]   good_status;
   logic [OUT_COUNT_BITS-1:0] frame_count;
   logic [OUT_COUNT_BITS-1:0] error_count;

   // Bit-serial form of the CRC: feedback is the CRC MSB xor the data bit.
   function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      logic       feedback;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = acc[7] ^ data[i];
         acc = {acc[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [ANGLE_BITS-1:0] angle_to_degrees(
      input logic [ANGLE_BITS-1:0] count
   );
      logic [MULT_WIDTH-1:0] product;
      product = MULT_WIDTH'(count) * MULT_WIDTH'(FULL_TURN_DEG);
      return ANGLE_BITS'(product >> (ANGLE_BITS - FRACTION_BITS));
   endfunction

   task automatic track_frame_byte(input logic [7:0] rx_byte, input logic frame_start);
      angle_reading_type reading;
      if (frame_start) begin
         frame_pos = POS_ECHO_0;
      end
      if (frame_pos == POS_ECHO_0) begin
         frame_crc = CRC_INIT;
         payload   = '0;
      end
      case (frame_pos)
         POS_DATA_0, POS_DATA_1, POS_DATA_2: begin
            frame_crc = crc_update(frame_crc, rx_byte);
            payload   = {payload[PAYLOAD_BITS-9:0], rx_byte};
            frame_pos = pos_type'(frame_pos + 3'd1);
         end
         POS_CHECK: begin
            frame_pos   = POS_ECHO_0;
            frame_count = frame_count + 1'b1;
            reading.crc_ok = (frame_crc == rx_byte);
            if (reading.crc_ok) begin
               good_angle  = payload[PAYLOAD_BITS-1:STATUS_WIDTH];
               good_status = payload[STATUS_WIDTH-1:0];
            end else begin
               error_count = error_count + 1'b1;
            end
            reading.angle   = good_angle;
            reading.degrees = angle_to_degrees(good_angle);
            reading.status  = good_status;
            reading.frames  = frame_count;
            reading.errors  = error_count;
            expected_readings.push_back(reading);
         end
         default: begin
            frame_pos = pos_type'(frame_pos + 3'd1);
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [31:0] want_value,
                                input logic [31:0] got_value);
      if (want_value !== got_value) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h",
                  $time, name, want_value, got_value);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      angle_reading_type got;
      angle_reading_type want;
      if (reset) begin
         frame_pos   = POS_ECHO_0;
         frame_crc   = CRC_INIT;
         payload     = '0;
         good_angle  = '0;
         good_status = '0;
         frame_count = '0;
         error_count = '0;
         expected_readings.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.crc_ok  = rsp_tuser[0];
            got.angle   = rsp_tdata[20:0];
            got.degrees = rsp_tdata[41:21];
            got.status  = rsp_tdata[44:42];
            got.frames  = rsp_tdata[76:45];
            got.errors  = rsp_tdata[108:77];
            if (expected_readings.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0h/%0h",
                        $time, rsp_tuser, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_readings.pop_front();
               compare_field("crc_ok", 32'(want.crc_ok), 32'(got.crc_ok));
               compare_field("angle_count", 32'(want.angle), 32'(got.angle));
               compare_field("angle_degrees", 32'(want.degrees), 32'(got.degrees));
               compare_field("sensor_status", 32'(want.status), 32'(got.status));
               compare_field("frames_seen", want.frames, got.frames);
               compare_field("crc_failures", want.errors, got.errors);
            end
         end
         if (req_tvalid && req_tready) begin
            track_frame_byte(req_tdata, req_tuser[0]);
         end
      end
      readings_pending = expected_readings.size();
   end

endmodule

// ===== sim/encoder_angle_frame_checker_test.sv =====
// Top of the encoder angle frame checker test: clock, reset, frame stimulus
// and result back-pressure; depends on eafc_pkg and the scoreboard module.
`timescale 1ns / 100ps

module encoder_angle_frame_checker_test;
   import eafc_pkg::*;

   localparam int RANDOM_ITEMS = 1150;
   localparam int HOLD_CYCLES  = 300;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic [REQ_USER_WIDTH-1:0] req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [RSP_USER_WIDTH-1:0] rsp_tuser;

   int   mismatch_count;
   int   readings_pending;
   int   bytes_sent = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic hold_request = 1'b0;
   logic resync_needed;

   encoder_angle_frame_checker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   encoder_angle_frame_checker_check frame_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .mismatch_count   (mismatch_count),
      .readings_pending (readings_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin : receiver
      logic hold_served;
      hold_served = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] rx_byte, input logic frame_start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx_byte;
      req_tuser  <= frame_start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [ANGLE_BITS-1:0] angle,
                             input logic [STATUS_WIDTH-1:0] status,
                             input logic crc_good, input logic mark_start);
      logic [PAYLOAD_BITS-1:0] payload_word;
      logic [7:0]              check;
      payload_word = {angle, status};
      check = CRC_INIT;
      check = crc_byte(check, payload_word[23:16]);
      check = crc_byte(check, payload_word[15:8]);
      check = crc_byte(check, payload_word[7:0]);
      if (!crc_good) begin
         check = check ^ 8'($urandom_range(1, 255));
      end
      send_byte(8'($urandom), mark_start);
      send_byte(8'($urandom), 1'b0);
      send_byte(payload_word[23:16], 1'b0);
      send_byte(payload_word[15:8], 1'b0);
      send_byte(payload_word[7:0], 1'b0);
      send_byte(check, 1'b0);
   endtask

   // Stray bytes and broken frames; the frame position is unknown afterwards.
   task automatic send_noise();
      int count;
      count = $urandom_range(1, 8);
      repeat (count) begin
         send_byte(8'($urandom), ($urandom_range(3) == 0));
      end
      resync_needed = 1'b1;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (readings_pending != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [ANGLE_BITS-1:0] angle;
      int                    phase_end;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      resync_needed = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The first byte after reset is byte 0 even without a frame start.
      send_frame({ANGLE_BITS{1'b1}}, 3'h7, 1'b1, 1'b0);
      // A bad check byte keeps the previous reading.
      send_frame(21'h0ABCDE, 3'h5, 1'b0, 1'b1);
      // A frame start in the middle of the payload drops the partial frame.
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_frame('0, 3'h0, 1'b1, 1'b1);
      // Back to back with no frame start.
      send_frame(21'h100000, 3'h2, 1'b1, 1'b0);
      wait_for_results();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 7;
               recv_idle_pct = 81;
            end
            1: begin
               send_idle_pct = 81;
               recv_idle_pct = 7;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_request <= 1'b1;
            end
         endcase
         phase_end = RANDOM_ITEMS * (phase + 1) / 3;
         while (bytes_sent < phase_end) begin
            if ($urandom_range(99) < 85) begin
               case ($urandom_range(9))
                  0:       angle = '0;
                  1:       angle = {ANGLE_BITS{1'b1}};
                  default: angle = ANGLE_BITS'($urandom);
               endcase
               send_frame(angle, 3'($urandom), ($urandom_range(3) != 0),
                          resync_needed || ($urandom_range(99) < 60));
               resync_needed = 1'b0;
            end else begin
               send_noise();
            end
         end
         wait_for_results();
      end

      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
